### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the top-level RTL file. All are clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant violated");

// When ante holds, cons must hold in the same cycle
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

`endif

### rtl/core/uflc_pkg.sv
// ----------------------------------------------------------------------------
// uflc_pkg
// Shared types and constants of the union-find link/compress engine:
// transaction payloads, command codes, and controller/datapath interface.
// ----------------------------------------------------------------------------
package uflc_pkg;

    // Parent table geometry; every 16-bit label addresses a valid entry
    localparam int unsigned VERTEX_COUNT = 65536;
    localparam int unsigned VERTEX_W     = $clog2(VERTEX_COUNT);

    typedef logic [VERTEX_W-1:0] vertex_t;

    // Command codes; code 3 is reserved, leaves the table unchanged and returns a zero result
    typedef enum logic [1:0] {
        CMD_LINK      = 2'd0,
        CMD_LINK_SKIP = 2'd1,
        CMD_COMPRESS  = 2'd2
    } cmd_code_t;

    // Input transaction
    typedef struct packed {
        logic [1:0] cmd;
        vertex_t    vertex_a;
        vertex_t    vertex_b;
    } cmd_item_t;

    // Result transaction
    typedef struct packed {
        vertex_t root;
        logic    changed;
        logic    skipped;
    } rsp_item_t;

    // Read address sources
    typedef enum logic [2:0] {
        RD_IN_A,    // vertex_a of the transaction being accepted
        RD_A,       // latched vertex_a
        RD_B,       // latched vertex_b
        RD_DATA,    // last read data (pointer chase)
        RD_LOW,     // latched low label
        RD_HIGH     // larger of work register and read data
    } rd_src_t;

    // Write operations
    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,     // entry[count] = count
        WR_COMPRESS,  // entry[a] = read data
        WR_LINK       // entry[high] = low
    } wr_op_t;

    // Work register sources
    typedef enum logic {
        WORK_IN_A,
        WORK_DATA
    } work_src_t;

    // Controller to datapath
    typedef struct packed {
        logic      load_item;
        rd_src_t   rd_sel;
        wr_op_t    wr_sel;
        logic      work_load;
        work_src_t work_src;
        logic      hl_load;
        logic      set_root;
        logic      set_changed;
        logic      set_skipped;
        logic      push;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic data_eq_work;
        logic data_eq_low;
        logic data_eq_high;
        logic work_eq_skip;
        logic clr_last;
    } dp_stat_t;

endpackage

### rtl/core/uflc_datapath.sv
// ----------------------------------------------------------------------------
// uflc_datapath
// Parent table memory, pointer-chase registers, comparators and the result
// register of the union-find engine.
// ----------------------------------------------------------------------------
module uflc_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  uflc_pkg::cmd_item_t cmd_data,
    input  uflc_pkg::vertex_t  skip_root,
    input  uflc_pkg::dp_cmd_t  dp_cmd,
    output uflc_pkg::dp_stat_t dp_stat,
    output uflc_pkg::rsp_item_t rsp_data
);

    // Parent table, one read and one write per cycle
    uflc_pkg::vertex_t parent_mem [uflc_pkg::VERTEX_COUNT];
    uflc_pkg::vertex_t rdata_reg;

    uflc_pkg::vertex_t a_reg;
    uflc_pkg::vertex_t b_reg;
    uflc_pkg::vertex_t work_reg;
    uflc_pkg::vertex_t work_next;
    uflc_pkg::vertex_t high_reg;
    uflc_pkg::vertex_t low_reg;
    uflc_pkg::vertex_t clr_cnt_reg;
    uflc_pkg::vertex_t clr_cnt_next;

    uflc_pkg::vertex_t root_reg;
    logic              changed_reg;
    logic              skipped_reg;
    uflc_pkg::rsp_item_t rsp_reg;

    uflc_pkg::vertex_t high_c;
    uflc_pkg::vertex_t low_c;
    uflc_pkg::vertex_t rd_addr;
    uflc_pkg::vertex_t wr_addr;
    uflc_pkg::vertex_t wr_data;
    logic              wr_en;

    // Order the pair (work, read data)
    assign high_c = (work_reg > rdata_reg) ? work_reg : rdata_reg;
    assign low_c  = (work_reg > rdata_reg) ? rdata_reg : work_reg;

    // Read address select
    always_comb
    begin
        unique case (dp_cmd.rd_sel)
            uflc_pkg::RD_IN_A: rd_addr = cmd_data.vertex_a;
            uflc_pkg::RD_A:    rd_addr = a_reg;
            uflc_pkg::RD_B:    rd_addr = b_reg;
            uflc_pkg::RD_DATA: rd_addr = rdata_reg;
            uflc_pkg::RD_LOW:  rd_addr = low_reg;
            uflc_pkg::RD_HIGH: rd_addr = high_c;
            default:           rd_addr = rdata_reg;
        endcase
    end

    // Write port select
    always_comb
    begin
        wr_en = 1'b1;
        unique case (dp_cmd.wr_sel)
            uflc_pkg::WR_CLEAR:
            begin
                wr_addr = clr_cnt_reg;
                wr_data = clr_cnt_reg;
            end
            uflc_pkg::WR_COMPRESS:
            begin
                wr_addr = a_reg;
                wr_data = rdata_reg;
            end
            uflc_pkg::WR_LINK:
            begin
                wr_addr = high_reg;
                wr_data = low_reg;
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_addr = a_reg;
                wr_data = rdata_reg;
            end
        endcase
    end

    // Memory: read-first, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            parent_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= parent_mem[rd_addr];
    end

    assign work_next = (dp_cmd.work_src == uflc_pkg::WORK_IN_A) ? cmd_data.vertex_a
                                                                : rdata_reg;
    assign clr_cnt_next = clr_cnt_reg + uflc_pkg::vertex_t'(1);

    // Clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (dp_cmd.wr_sel == uflc_pkg::WR_CLEAR)
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Working registers and results
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_item)
        begin
            a_reg       <= cmd_data.vertex_a;
            b_reg       <= cmd_data.vertex_b;
            root_reg    <= '0;
            changed_reg <= 1'b0;
            skipped_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.set_root)
            begin
                root_reg <= work_reg;
            end
            if (dp_cmd.set_changed)
            begin
                changed_reg <= 1'b1;
            end
            if (dp_cmd.set_skipped)
            begin
                skipped_reg <= 1'b1;
            end
        end
        if (dp_cmd.work_load)
        begin
            work_reg <= work_next;
        end
        if (dp_cmd.hl_load)
        begin
            high_reg <= high_c;
            low_reg  <= low_c;
        end
        if (dp_cmd.push)
        begin
            rsp_reg.root    <= root_reg;
            rsp_reg.changed <= changed_reg;
            rsp_reg.skipped <= skipped_reg;
        end
    end

    // Status toward the controller
    assign dp_stat.data_eq_work = (rdata_reg == work_reg);
    assign dp_stat.data_eq_low  = (rdata_reg == low_reg);
    assign dp_stat.data_eq_high = (rdata_reg == high_reg);
    assign dp_stat.work_eq_skip = (work_reg == skip_root);
    assign dp_stat.clr_last     = (clr_cnt_reg == uflc_pkg::vertex_t'(uflc_pkg::VERTEX_COUNT - 1));

    assign rsp_data = rsp_reg;

endmodule

### rtl/core/uflc_ctrl.sv
// ----------------------------------------------------------------------------
// uflc_ctrl
// Sequencer of the union-find engine: table clearing pass, compress walk,
// root search for skip checks, Afforest link climb, and result handoff.
// ----------------------------------------------------------------------------
module uflc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic [1:0]         cmd_op,
    output logic               cmd_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  uflc_pkg::dp_stat_t dp_stat,
    output uflc_pkg::dp_cmd_t  dp_cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_C_RD_P,
        ST_C_CHK,
        ST_F_CHK,
        ST_L_RD_B,
        ST_L_CMP,
        ST_L_PH,
        ST_L_RD_LOW,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        dp_cmd.rd_sel   = uflc_pkg::RD_DATA;
        dp_cmd.wr_sel   = uflc_pkg::WR_NONE;
        dp_cmd.work_src = uflc_pkg::WORK_DATA;
        unique case (state_reg)
            ST_CLEAR:
            begin
                dp_cmd.wr_sel = uflc_pkg::WR_CLEAR;
                if (dp_stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // Start reading parent[a] while the transaction is taken
                dp_cmd.rd_sel   = uflc_pkg::RD_IN_A;
                dp_cmd.work_src = uflc_pkg::WORK_IN_A;
                if (cmd_valid)
                begin
                    dp_cmd.load_item = 1'b1;
                    dp_cmd.work_load = 1'b1;
                    unique case (cmd_op)
                        uflc_pkg::CMD_LINK:      state_next = ST_L_RD_B;
                        uflc_pkg::CMD_LINK_SKIP: state_next = ST_F_CHK;
                        uflc_pkg::CMD_COMPRESS:  state_next = ST_C_RD_P;
                        default:                 state_next = ST_RESP;
                    endcase
                end
            end
            ST_C_RD_P:
            begin
                // work = p, read grandparent
                dp_cmd.work_load = 1'b1;
                state_next       = ST_C_CHK;
            end
            ST_C_CHK:
            begin
                if (dp_stat.data_eq_work)
                begin
                    dp_cmd.set_root = 1'b1;
                    state_next      = ST_RESP;
                end
                else
                begin
                    // parent[a] = g, then climb from g
                    dp_cmd.wr_sel      = uflc_pkg::WR_COMPRESS;
                    dp_cmd.set_changed = 1'b1;
                    dp_cmd.work_load   = 1'b1;
                end
            end
            ST_F_CHK:
            begin
                if (dp_stat.data_eq_work)
                begin
                    if (dp_stat.work_eq_skip)
                    begin
                        dp_cmd.set_skipped = 1'b1;
                        state_next         = ST_RESP;
                    end
                    else
                    begin
                        dp_cmd.rd_sel = uflc_pkg::RD_A;
                        state_next    = ST_L_RD_B;
                    end
                end
                else
                begin
                    dp_cmd.work_load = 1'b1;
                end
            end
            ST_L_RD_B:
            begin
                // work = p1, read p2
                dp_cmd.work_load = 1'b1;
                dp_cmd.rd_sel    = uflc_pkg::RD_B;
                state_next       = ST_L_CMP;
            end
            ST_L_CMP:
            begin
                if (dp_stat.data_eq_work)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    dp_cmd.hl_load = 1'b1;
                    dp_cmd.rd_sel  = uflc_pkg::RD_HIGH;
                    state_next     = ST_L_PH;
                end
            end
            ST_L_PH:
            begin
                if (dp_stat.data_eq_low)
                begin
                    state_next = ST_RESP;
                end
                else if (dp_stat.data_eq_high)
                begin
                    // high is a root: hook it under low
                    dp_cmd.wr_sel      = uflc_pkg::WR_LINK;
                    dp_cmd.set_changed = 1'b1;
                    state_next         = ST_RESP;
                end
                else
                begin
                    state_next = ST_L_RD_LOW;
                end
            end
            ST_L_RD_LOW:
            begin
                // work = parent[ph], read parent[low]
                dp_cmd.work_load = 1'b1;
                dp_cmd.rd_sel    = uflc_pkg::RD_LOW;
                state_next       = ST_L_CMP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    dp_cmd.push = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output slot occupancy
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (dp_cmd.push)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

### rtl/core/union_find_link_compress.sv
// ----------------------------------------------------------------------------
// union_find_link_compress
// Union-find engine over a 65536-entry parent table: Afforest-style edge
// linking, optional skip of a configured component, and path compression.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that sets every parent entry to
// its own index; cmd_stall stays high until it ends, while skip_root can
// already be written. All work goes through the parent table, which has one
// read port and one write port, one read per cycle, so every pointer that a
// transaction chases costs a table read. A compress climbs from vertex_a's
// parent to its root, rewriting parent[vertex_a] at each extra level. A link
// (cmd 0) hooks the larger of the two parents under the smaller when it is a
// root, else climbs a step. A link with skip check (cmd 1) first walks from
// vertex_a to its root and skips the link if that is skip_root. A reserved
// command returns a result without touching the table. A new transaction is
// taken while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module union_find_link_compress
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Command channel
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  uflc_pkg::cmd_item_t cmd_data,
    // Result channel
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output uflc_pkg::rsp_item_t rsp_data
);

    // Register index carried in paddr[2]
    localparam logic REG_SKIP_ROOT = 1'b0;

    uflc_pkg::vertex_t  skip_root_reg;
    uflc_pkg::dp_cmd_t  dp_cmd;
    uflc_pkg::dp_stat_t dp_stat;
    logic               cfg_write;
    logic               table_write;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_root_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == REG_SKIP_ROOT))
        begin
            skip_root_reg <= pwdata[uflc_pkg::VERTEX_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SKIP_ROOT)
                    ? {{(32 - uflc_pkg::VERTEX_W){1'b0}}, skip_root_reg}
                    : 32'd0;

    uflc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_op    (cmd_data.cmd),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    uflc_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd_data),
        .skip_root (skip_root_reg),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat),
        .rsp_data  (rsp_data)
    );

    // Compress or link rewrite of a parent entry
    assign table_write = (dp_cmd.wr_sel == uflc_pkg::WR_COMPRESS)
                         || (dp_cmd.wr_sel == uflc_pkg::WR_LINK);

    // No transaction is taken during the clearing pass
    `ASSERT_IMPLIES(a_clear_blocks_cmd, dp_cmd.wr_sel == uflc_pkg::WR_CLEAR, cmd_stall)
    // A table rewrite is always reported
    `ASSERT_IMPLIES(a_write_flags_change, table_write, dp_cmd.set_changed)
    // A result is never loaded over one that is still held
    `ASSERT_IMPLIES(a_push_slot_free, dp_cmd.push, !rsp_valid || !rsp_stall)
    // A skipped link never rewrites the table
    `ASSERT_ALWAYS(a_skip_not_changed, !(rsp_valid && rsp_data.changed && rsp_data.skipped))

endmodule
